// ===== sv/apsa_pkg.sv =====
// Shared types, constants and helpers for the audio packet size adapter.
package apsa_pkg;

    // Table depth and derived widths.
    localparam int MAX_CHANNELS = 16;
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

    // Packet size steps in ms.
    localparam logic [6:0] PKT_20MS = 7'd20;
    localparam logic [6:0] PKT_40MS = 7'd40;
    localparam logic [6:0] PKT_60MS = 7'd60;
    localparam logic [7:0] PKT_STEP_MS = 8'd20;
    localparam logic [7:0] PKT_CAP_MS = 8'd40;

    // Channel counts at which the floor rises.
    localparam int FLOWS_FOR_40MS = 2;
    localparam int FLOWS_FOR_60MS = 4;

    // Command codes.
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_STATS = 1'b1;

    // Status codes.
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SHORT_RTT = 3'd0;
    localparam logic [2:0] CFG_LONG_RTT = 3'd1;
    localparam logic [2:0] CFG_LOW_LOSS = 3'd2;
    localparam logic [2:0] CFG_HIGH_LOSS = 3'd3;
    localparam logic [2:0] CFG_HIGH_RATE = 3'd4;
    localparam logic [2:0] CFG_LOW_RATE = 3'd5;
    localparam logic [2:0] CFG_FORCED_RATE = 3'd6;
    localparam logic [2:0] CFG_FORCED_PKT = 3'd7;

    // Input item.
    typedef struct packed {
        logic        command;
        logic [9:0]  channel_id;
        logic [15:0] rtt_ms;
        logic [7:0]  loss_q8;
    } in_t;

    // Result item.
    typedef struct packed {
        logic        status;
        logic [6:0]  applied_packet_ms;
        logic [18:0] applied_rate_bps;
        logic        settings_changed;
        logic [15:0] worst_rtt_ms;
        logic [7:0]  worst_loss_q8;
    } out_t;

    // Token that walks the cell chain, gathering the maxima.
    typedef struct packed {
        logic        valid;
        logic        cmd;
        logic [9:0]  chan;
        logic [15:0] rtt;
        logic [7:0]  loss;
        logic [15:0] max_rtt;
        logic [7:0]  max_loss;
    } tok_t;

    // Floor packet size for a given channel count.
    function automatic logic [6:0] floor_for_count(input logic [CNT_W-1:0] n);
        logic [6:0] f;
        if (int'(n) >= FLOWS_FOR_60MS)
        begin
            f = PKT_60MS;
        end
        else if (int'(n) >= FLOWS_FOR_40MS)
        begin
            f = PKT_40MS;
        end
        else
        begin
            f = PKT_20MS;
        end
        return f;
    endfunction

endpackage

// ===== sv/apsa_cell.sv =====
// One table entry of the channel chain: stores a channel's report and folds it into the token.
module apsa_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               add_en,
    input  logic [9:0]         add_chan,
    input  apsa_pkg::tok_t     tok_in,
    output apsa_pkg::tok_t     tok_out
);

    logic        valid_reg;
    logic [9:0]  chan_reg;
    logic [15:0] rtt_reg;
    logic [7:0]  loss_reg;
    apsa_pkg::tok_t tok_reg;
    apsa_pkg::tok_t tok_next;

    logic        match;
    logic [15:0] eff_rtt;
    logic [7:0]  eff_loss;

    // A stats token that names this entry's channel overwrites the report.
    assign match = valid_reg && tok_in.valid && (tok_in.cmd == apsa_pkg::CMD_STATS)
                   && (chan_reg == tok_in.chan);
    assign eff_rtt = match ? tok_in.rtt : rtt_reg;
    assign eff_loss = match ? tok_in.loss : loss_reg;

    // Fold this entry into the running maxima.
    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg && (eff_rtt > tok_in.max_rtt))
        begin
            tok_next.max_rtt = eff_rtt;
        end
        if (valid_reg && (eff_loss > tok_in.max_loss))
        begin
            tok_next.max_loss = eff_loss;
        end
    end

    // Entry valid bit and the hand-off register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            if (add_en)
            begin
                valid_reg <= 1'b1;
            end
            tok_reg <= tok_next;
        end
    end

    // Entry payload.
    always_ff @(posedge clk)
    begin
        if (add_en)
        begin
            chan_reg <= add_chan;
            rtt_reg <= '0;
            loss_reg <= '0;
        end
        else if (match)
        begin
            rtt_reg <= tok_in.rtt;
            loss_reg <= tok_in.loss;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sv/audio_packet_size_adapter_core.sv =====
// Top level of the audio packet size adapter: control, configuration and the cell chain.
//
//   Port group   Direction  Handshake              Contents
//   in_*         input      in_valid / in_ready    in_item (apsa_pkg::in_t)
//   out_*        output     out_valid / out_ready  out_item (apsa_pkg::out_t)
//   cfg_*        input      cfg_we                 cfg_index, cfg_data
//
// One item at a time: out_valid rises once the token, walking one cell per cycle, has
// left the last cell of the chain.
// An add writes its entry at the acceptance edge; the token then leaves the next cycle.
// in_ready stays low from acceptance until the result item is taken.
// A stalled result holds in the output register. Reset clears the table and all control.
module audio_packet_size_adapter_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  apsa_pkg::in_t      in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output apsa_pkg::out_t     out_item,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [18:0]        cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Configuration registers.
    logic [15:0] short_rtt_reg;
    logic [15:0] long_rtt_reg;
    logic [7:0]  low_loss_reg;
    logic [7:0]  high_loss_reg;
    logic [18:0] high_rate_reg;
    logic [18:0] low_rate_reg;
    logic [18:0] forced_rate_reg;
    logic [6:0]  forced_pkt_reg;

    // Adaptation state.
    logic [apsa_pkg::CNT_W-1:0] count_reg;
    logic [6:0]  floor_reg;
    logic [6:0]  adaptive_reg;
    logic [18:0] rate_reg;
    logic        status_reg;

    // Current item and launch pulse.
    apsa_pkg::in_t item_reg;
    logic          launch_reg;

    // Result register.
    logic           out_valid_reg;
    apsa_pkg::out_t out_reg;
    apsa_pkg::out_t out_next;

    logic in_acc;
    logic out_acc;
    logic add_ok;
    logic [apsa_pkg::IDX_W-1:0] add_idx;

    apsa_pkg::tok_t tok_head;
    apsa_pkg::tok_t tok_chain [0:apsa_pkg::MAX_CHANNELS];
    apsa_pkg::tok_t tail;

    logic       good;
    logic       bad;
    logic [7:0] adp;
    logic [7:0] p_step;
    logic [7:0] p_floor;
    logic [6:0] p_new;
    logic       changed;
    logic [6:0] adaptive_next;
    logic [18:0] rate_next;
    logic [6:0] applied_pkt;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid_reg && out_ready;
    assign add_ok = in_acc && (in_item.command == apsa_pkg::CMD_ADD)
                    && (int'(count_reg) < apsa_pkg::MAX_CHANNELS);
    assign add_idx = count_reg[apsa_pkg::IDX_W-1:0];

    // Token entering the first cell.
    always_comb
    begin
        tok_head = '0;
        tok_head.valid = launch_reg;
        tok_head.cmd = item_reg.command;
        tok_head.chan = item_reg.channel_id;
        tok_head.rtt = item_reg.rtt_ms;
        tok_head.loss = item_reg.loss_q8;
    end

    assign tok_chain[0] = tok_head;

    // The chain of table entries.
    for (genvar i = 0; i < apsa_pkg::MAX_CHANNELS; i++)
    begin : g_cell
        apsa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .add_en   (add_ok && (add_idx == apsa_pkg::IDX_W'(i))),
            .add_chan (in_item.channel_id),
            .tok_in   (tok_chain[i]),
            .tok_out  (tok_chain[i+1])
        );
    end

    assign tail = tok_chain[apsa_pkg::MAX_CHANNELS];

    // Packet size adaptation from the gathered maxima.
    always_comb
    begin
        good = (tail.max_rtt < short_rtt_reg) && (tail.max_loss < low_loss_reg);
        bad = (tail.max_rtt > long_rtt_reg) || (tail.max_loss > high_loss_reg);
        adp = {1'b0, adaptive_reg};
        if (good)
        begin
            p_step = (adp >= apsa_pkg::PKT_STEP_MS) ? (adp - apsa_pkg::PKT_STEP_MS) : 8'd0;
        end
        else if (bad)
        begin
            p_step = adp + apsa_pkg::PKT_STEP_MS;
        end
        else
        begin
            p_step = adp;
        end
        p_floor = (p_step < {1'b0, floor_reg}) ? {1'b0, floor_reg} : p_step;
        p_new = (p_floor > apsa_pkg::PKT_CAP_MS) ? apsa_pkg::PKT_CAP_MS[6:0] : p_floor[6:0];
        changed = (tail.cmd == apsa_pkg::CMD_STATS) && (p_new != adaptive_reg);
        adaptive_next = changed ? p_new : adaptive_reg;
        if (changed)
        begin
            rate_next = (p_new == apsa_pkg::PKT_20MS) ? high_rate_reg : low_rate_reg;
        end
        else
        begin
            rate_next = rate_reg;
        end
        if (forced_pkt_reg != 7'd0)
        begin
            applied_pkt = forced_pkt_reg;
        end
        else
        begin
            applied_pkt = (adaptive_next > floor_reg) ? adaptive_next : floor_reg;
        end
        out_next.status = status_reg;
        out_next.applied_packet_ms = applied_pkt;
        out_next.applied_rate_bps = (forced_rate_reg != 19'd0) ? forced_rate_reg : rate_next;
        out_next.settings_changed = changed;
        out_next.worst_rtt_ms = tail.max_rtt;
        out_next.worst_loss_q8 = tail.max_loss;
    end

    // Control sequence.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and adaptation registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            launch_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg <= '0;
            floor_reg <= apsa_pkg::PKT_20MS;
            adaptive_reg <= apsa_pkg::PKT_20MS;
            rate_reg <= 19'd32000;
            status_reg <= apsa_pkg::STATUS_OK;
            short_rtt_reg <= 16'd500;
            long_rtt_reg <= 16'd800;
            low_loss_reg <= 8'd7;
            high_loss_reg <= 8'd25;
            high_rate_reg <= 19'd32000;
            low_rate_reg <= 19'd24000;
            forced_rate_reg <= '0;
            forced_pkt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            launch_reg <= in_acc;
            if (in_acc)
            begin
                if (in_item.command == apsa_pkg::CMD_ADD)
                begin
                    if (add_ok)
                    begin
                        count_reg <= count_reg + 1'b1;
                        floor_reg <= apsa_pkg::floor_for_count(count_reg + 1'b1);
                        status_reg <= apsa_pkg::STATUS_OK;
                    end
                    else
                    begin
                        floor_reg <= apsa_pkg::floor_for_count(count_reg);
                        status_reg <= apsa_pkg::STATUS_FULL;
                    end
                end
                else
                begin
                    status_reg <= apsa_pkg::STATUS_OK;
                end
            end
            if ((state_reg == ST_SCAN) && tail.valid)
            begin
                adaptive_reg <= adaptive_next;
                rate_reg <= rate_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    apsa_pkg::CFG_SHORT_RTT:   short_rtt_reg <= cfg_data[15:0];
                    apsa_pkg::CFG_LONG_RTT:    long_rtt_reg <= cfg_data[15:0];
                    apsa_pkg::CFG_LOW_LOSS:    low_loss_reg <= cfg_data[7:0];
                    apsa_pkg::CFG_HIGH_LOSS:   high_loss_reg <= cfg_data[7:0];
                    apsa_pkg::CFG_HIGH_RATE:   high_rate_reg <= cfg_data;
                    apsa_pkg::CFG_LOW_RATE:    low_rate_reg <= cfg_data;
                    apsa_pkg::CFG_FORCED_RATE: forced_rate_reg <= cfg_data;
                    apsa_pkg::CFG_FORCED_PKT:  forced_pkt_reg <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= in_item;
        end
        if ((state_reg == ST_SCAN) && tail.valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_reg;

`ifndef NO_ASSERTIONS
    // A result is only offered in the output state.
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_OUT))
        else $error("result offered outside the output state");

    // The token reaches the end of the chain only during a scan.
    a_tail_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == ST_SCAN))
        else $error("token left the chain outside a scan");

    // The channel count never passes the table depth.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= apsa_pkg::MAX_CHANNELS)
        else $error("channel count beyond table depth");

    // Every accepted item launches a token in the next cycle.
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (launch_reg && (state_reg == ST_SCAN)))
        else $error("accepted item did not launch a token");
`endif

endmodule
